### hw/rtl/priority_ready_queue_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define PRQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PRQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PRQS_ASSERT(lbl, prop, msg)
`define PRQS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/prqs_pkg.sv
package prqs_pkg;

  localparam int THREADS_DEF = 8;
  localparam int LEVELS_DEF  = 16;

  localparam int OP_W     = 3;
  localparam int TH_W     = 3;
  localparam int REQ_W    = 5;
  localparam int PRIO_W   = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TAKE    = 3'd0,
    OP_APPEND  = 3'd1,
    OP_SELECT  = 3'd2,
    OP_CHPRIO  = 3'd3,
    OP_SCHED   = 3'd4,
    OP_INSTALL = 3'd5,
    OP_CLEAR   = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_IGNORED    = 2'd1,
    ST_NO_CUR     = 2'd2,
    ST_NONE_READY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INST_CUR,
    S_INST_TH,
    S_APPEND,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic inst_cur;
    logic inst_th;
    logic append;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic go_install;
    logic go_append;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/prqs_if.sv
interface prqs_in_if;
  logic                                valid;
  logic                                ready;
  logic [prqs_pkg::OP_W-1:0]           op;
  logic [prqs_pkg::TH_W-1:0]           thread;
  logic signed [prqs_pkg::REQ_W-1:0]   priority_req;

  modport source (output valid, output op, output thread, output priority_req, input ready);
  modport sink   (input valid, input op, input thread, input priority_req, output ready);
endinterface

interface prqs_out_if;
  logic                              valid;
  logic                              ready;
  logic [prqs_pkg::STATUS_W-1:0]     status;
  logic [prqs_pkg::TH_W-1:0]         current_thread;
  logic                              current_valid;
  logic [prqs_pkg::PRIO_W-1:0]       old_priority;

  modport source (output valid, output status, output current_thread, output current_valid,
                  output old_priority, input ready);
  modport sink   (input valid, input status, input current_thread, input current_valid,
                  input old_priority, output ready);
endinterface

### hw/rtl/priority_ready_queue_scheduler.sv
// An accepted transaction runs a check step, then one step per queue update: an append for a
// priority change that requeues; for an install, requeue of an idle current, install, append.
// A result step then loads the output register, waiting while it holds an untaken result.
// The result waits there while the next transaction is taken; none is taken before the load.
// Reset (rst_ni low, asynchronous) empties every level, clears all ready flags and
// priorities and drops the current thread; no clearing pass is needed.
module priority_ready_queue_scheduler #(
  parameter int THREADS = prqs_pkg::THREADS_DEF,
  parameter int LEVELS  = prqs_pkg::LEVELS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  prqs_in_if.sink      in_i,
  prqs_out_if.source   out_o
);

  prqs_pkg::cmd_t cmd;
  prqs_pkg::sts_t sts;
  logic           in_ready;

  prqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prqs_dp #(
    .THREADS (THREADS),
    .LEVELS  (LEVELS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (in_i.op),
    .thread_i         (in_i.thread),
    .priority_req_i   (in_i.priority_req),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .status_o         (out_o.status),
    .current_thread_o (out_o.current_thread),
    .current_valid_o  (out_o.current_valid),
    .old_priority_o   (out_o.old_priority)
  );

  assign in_i.ready = in_ready;

endmodule

### hw/rtl/prqs_ctrl.sv
`include "priority_ready_queue_scheduler_defines.svh"

module prqs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  prqs_pkg::sts_t  sts_i,
  output prqs_pkg::cmd_t  cmd_o
);

  prqs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prqs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      prqs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = prqs_pkg::S_CHECK;
        end
      end
      prqs_pkg::S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.go_install) begin
          state_d = prqs_pkg::S_INST_CUR;
        end else if (sts_i.go_append) begin
          state_d = prqs_pkg::S_APPEND;
        end else begin
          state_d = prqs_pkg::S_RESULT;
        end
      end
      prqs_pkg::S_INST_CUR: begin
        cmd_o.inst_cur = 1'b1;
        state_d        = prqs_pkg::S_INST_TH;
      end
      prqs_pkg::S_INST_TH: begin
        cmd_o.inst_th = 1'b1;
        state_d       = prqs_pkg::S_APPEND;
      end
      prqs_pkg::S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = prqs_pkg::S_RESULT;
      end
      prqs_pkg::S_RESULT: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = prqs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prqs_pkg::S_IDLE;
      end
    endcase
  end

  `PRQS_ASSERT(a_accept_to_check, in_valid_i && in_ready_o |=> state_q == prqs_pkg::S_CHECK, "transaction accepted but no check follows")
  `PRQS_ASSERT(a_install_seq, state_q == prqs_pkg::S_INST_CUR |=> state_q == prqs_pkg::S_INST_TH, "install sequence broken")
  `PRQS_ASSERT(a_result_drain, state_q == prqs_pkg::S_RESULT && sts_i.out_free |=> state_q == prqs_pkg::S_IDLE, "result stage did not release")

endmodule

### hw/rtl/prqs_dp.sv
`include "priority_ready_queue_scheduler_defines.svh"

module prqs_dp #(
  parameter int THREADS = prqs_pkg::THREADS_DEF,
  parameter int LEVELS  = prqs_pkg::LEVELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  prqs_pkg::cmd_t                      cmd_i,
  output prqs_pkg::sts_t                      sts_o,
  input  logic [prqs_pkg::OP_W-1:0]           op_i,
  input  logic [prqs_pkg::TH_W-1:0]           thread_i,
  input  logic signed [prqs_pkg::REQ_W-1:0]   priority_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [prqs_pkg::STATUS_W-1:0]       status_o,
  output logic [prqs_pkg::TH_W-1:0]           current_thread_o,
  output logic                                current_valid_o,
  output logic [prqs_pkg::PRIO_W-1:0]         old_priority_o
);

  localparam int TIW = $clog2(THREADS);
  localparam int LKW = $clog2(THREADS + 1);
  localparam int LW  = $clog2(LEVELS);
  localparam int PW  = prqs_pkg::PRIO_W;
  localparam int TW  = prqs_pkg::TH_W;
  localparam logic [LKW-1:0] NONE = LKW'(THREADS);

  function automatic logic [PW-1:0] clamp_lvl(input logic [PW-1:0] v);
    clamp_lvl = (int'(v) >= LEVELS) ? PW'(LEVELS - 1) : v;
  endfunction

  // operation in flight
  prqs_pkg::op_e   op_q;
  logic [TW-1:0]   th_q;
  logic            keep_q;
  logic [PW-1:0]   req_q;
  logic [1:0]      status_q;
  logic            have_old_q;
  logic [PW-1:0]   oldp_q;

  // scheduler state
  logic [THREADS-1:0]  ready_q;
  logic [PW-1:0]       prio_q [THREADS];
  logic [LKW-1:0]      next_q [THREADS];
  logic [LKW-1:0]      head_q [LEVELS];
  logic [LKW-1:0]      tail_q [LEVELS];
  logic [LEVELS-1:0]   ne_q;
  logic [TIW-1:0]      cur_q;
  logic                present_q;

  // result register
  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [TW-1:0]       out_thread_q;
  logic                out_cvalid_q;
  logic [PW-1:0]       out_oldp_q;

  logic            sel_th, th_ok, in_rng, t_ready, cur_is_th;
  logic [TIW-1:0]  t_raw, t_idx;
  logic [PW-1:0]   t_prio, req_cl;
  logic [LW-1:0]   p_lvl, enc, lvl_idx;
  logic            any_ne, tail_ok, next_ok;
  logic [LKW-1:0]  head_rd, tail_rd, next_rd;

  prqs_pkg::status_e st_d;
  logic st_we, app_en, take_en, sel_en, sched_en, clr_en, setp_en, old_we;
  logic go_install, go_append;

  assign sel_th    = cmd_i.inst_th | (cmd_i.check & (op_q == prqs_pkg::OP_INSTALL));
  assign th_ok     = int'(th_q) < THREADS;
  assign t_raw     = sel_th ? TIW'(th_q) : cur_q;
  assign in_rng    = int'(t_raw) < THREADS;
  assign t_idx     = in_rng ? t_raw : '0;
  assign t_ready   = in_rng & ready_q[t_idx];
  assign t_prio    = prio_q[t_idx];
  assign p_lvl     = LW'(clamp_lvl(t_prio));
  assign req_cl    = clamp_lvl(req_q);
  assign cur_is_th = present_q && (int'(cur_q) == int'(th_q));

  always_comb begin
    enc = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ne_q[i]) begin
        enc = LW'(i);
      end
    end
  end

  assign any_ne  = |ne_q;
  assign lvl_idx = (cmd_i.check && op_q == prqs_pkg::OP_SCHED) ? enc : p_lvl;
  assign head_rd = head_q[lvl_idx];
  assign tail_rd = tail_q[p_lvl];
  assign next_rd = next_q[cur_q];
  assign tail_ok = int'(tail_rd) < THREADS;
  assign next_ok = int'(next_rd) < THREADS;

  always_comb begin
    st_d       = prqs_pkg::ST_IGNORED;
    st_we      = 1'b0;
    app_en     = 1'b0;
    take_en    = 1'b0;
    sel_en     = 1'b0;
    sched_en   = 1'b0;
    clr_en     = 1'b0;
    setp_en    = 1'b0;
    old_we     = 1'b0;
    go_install = 1'b0;
    go_append  = 1'b0;
    if (cmd_i.check) begin
      st_we = 1'b1;
      case (op_q)
        prqs_pkg::OP_TAKE: begin
          if (!present_q) begin
            st_d = prqs_pkg::ST_NO_CUR;
          end else if (t_ready && head_rd == LKW'(cur_q)) begin
            take_en = 1'b1;
            st_d    = prqs_pkg::ST_DONE;
          end
        end
        prqs_pkg::OP_APPEND: begin
          if (!present_q) begin
            st_d = prqs_pkg::ST_NO_CUR;
          end else if (!t_ready) begin
            app_en = 1'b1;
            st_d   = prqs_pkg::ST_DONE;
          end
        end
        prqs_pkg::OP_SELECT: begin
          if (th_ok && !cur_is_th) begin
            sel_en = 1'b1;
            st_d   = prqs_pkg::ST_DONE;
          end
        end
        prqs_pkg::OP_CHPRIO: begin
          if (!present_q) begin
            st_d = prqs_pkg::ST_NO_CUR;
          end else begin
            old_we = 1'b1;
            if (!t_ready) begin
              setp_en   = !keep_q;
              go_append = 1'b1;
              st_d      = prqs_pkg::ST_DONE;
            end
          end
        end
        prqs_pkg::OP_SCHED: begin
          if (any_ne) begin
            sched_en = 1'b1;
            st_d     = prqs_pkg::ST_DONE;
          end else begin
            st_d = prqs_pkg::ST_NONE_READY;
          end
        end
        prqs_pkg::OP_INSTALL: begin
          if (th_ok && !t_ready) begin
            go_install = 1'b1;
            st_d       = prqs_pkg::ST_DONE;
          end
        end
        prqs_pkg::OP_CLEAR: begin
          if (present_q) begin
            clr_en = 1'b1;
            st_d   = prqs_pkg::ST_DONE;
          end
        end
        default: begin
          st_d = prqs_pkg::ST_IGNORED;
        end
      endcase
    end
    // an idle previous current goes back on its queue before the install
    if (cmd_i.inst_cur) begin
      app_en = present_q && !t_ready;
    end
    if (cmd_i.inst_th) begin
      setp_en = !keep_q;
      sel_en  = 1'b1;
    end
    if (cmd_i.append) begin
      app_en = 1'b1;
    end
  end

  assign sts_o.go_install = go_install;
  assign sts_o.go_append  = go_append;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= prqs_pkg::OP_TAKE;
      th_q        <= '0;
      keep_q      <= 1'b0;
      req_q       <= '0;
      status_q    <= '0;
      have_old_q  <= 1'b0;
      oldp_q      <= '0;
      ready_q     <= '0;
      ne_q        <= '0;
      cur_q       <= '0;
      present_q   <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        prio_q[i] <= '0;
        next_q[i] <= NONE;
      end
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= NONE;
        tail_q[i] <= NONE;
      end
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_thread_q <= '0;
      out_cvalid_q <= 1'b0;
      out_oldp_q   <= '0;
    end else begin
      if (cmd_i.capture) begin
        op_q       <= prqs_pkg::op_e'(op_i);
        th_q       <= thread_i;
        keep_q     <= priority_req_i[prqs_pkg::REQ_W-1];
        req_q      <= priority_req_i[PW-1:0];
        have_old_q <= 1'b0;
      end
      if (st_we) begin
        status_q <= st_d;
      end
      if (old_we) begin
        oldp_q     <= t_prio;
        have_old_q <= 1'b1;
      end
      if (setp_en) begin
        prio_q[t_idx] <= req_cl;
      end
      if (take_en) begin
        ready_q[t_idx] <= 1'b0;
        next_q[t_idx]  <= NONE;
        ne_q[p_lvl]    <= next_ok;
        if (next_ok) begin
          head_q[p_lvl] <= next_rd;
        end else begin
          head_q[p_lvl] <= NONE;
          tail_q[p_lvl] <= NONE;
        end
      end
      if (app_en) begin
        if (tail_ok) begin
          next_q[TIW'(tail_rd)] <= LKW'(t_idx);
        end else begin
          head_q[p_lvl] <= LKW'(t_idx);
          ne_q[p_lvl]   <= 1'b1;
        end
        tail_q[p_lvl]  <= LKW'(t_idx);
        ready_q[t_idx] <= 1'b1;
        next_q[t_idx]  <= NONE;
      end
      if (sel_en) begin
        cur_q     <= TIW'(th_q);
        present_q <= 1'b1;
      end
      if (sched_en) begin
        cur_q     <= TIW'(head_rd);
        present_q <= 1'b1;
      end
      if (clr_en) begin
        present_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        out_thread_q <= present_q ? TW'(cur_q) : '0;
        out_cvalid_q <= present_q;
        out_oldp_q   <= have_old_q ? oldp_q : (present_q ? t_prio : '0);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign current_thread_o = out_thread_q;
  assign current_valid_o  = out_cvalid_q;
  assign old_priority_o   = out_oldp_q;

  `PRQS_ASSERT(a_load_needs_room, cmd_i.load_out |-> !out_valid_q || out_ready_i, "result loaded over a pending transaction")
  `PRQS_ASSERT(a_sched_sets_cur, cmd_i.check && op_q == prqs_pkg::OP_SCHED && any_ne |=> present_q, "schedule found a level but no current thread")
  `PRQS_ASSERT_ALWAYS(a_cur_in_range, present_q |-> int'(cur_q) < THREADS, "current thread index out of range")

endmodule

### tb/sv/prqs_checker.sv
`timescale 1ns / 1ps

module prqs_checker
  import prqs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  prqs_in_if   cmd_i,
  prqs_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  localparam int              NTH     = THREADS_DEF;
  localparam int              NLVL    = LEVELS_DEF;
  localparam logic [TH_W:0]   NO_LINK = (TH_W + 1)'(NTH);

  typedef struct packed {
    status_e             status;
    logic [TH_W-1:0]     thread;
    logic                valid;
    logic [PRIO_W-1:0]   prio;
  } sched_result_t;

  logic              rdy      [NTH];
  logic [PRIO_W-1:0] prio     [NTH];
  logic [TH_W:0]     link     [NTH];
  logic [TH_W:0]     head     [NLVL];
  logic [TH_W:0]     tail     [NLVL];
  logic [TH_W-1:0]   cur;
  logic              cur_held;

  sched_result_t     expected_q[$];
  int                fails;
  int                checked;

  function automatic void clear_queues();
    for (int i = 0; i < NTH; i++) begin
      rdy[i]  = 1'b0;
      prio[i] = '0;
      link[i] = NO_LINK;
    end
    for (int i = 0; i < NLVL; i++) begin
      head[i] = NO_LINK;
      tail[i] = NO_LINK;
    end
    cur      = '0;
    cur_held = 1'b0;
  endfunction

  // push thread t on the tail of its own level
  function automatic void enqueue(input logic [TH_W-1:0] t);
    logic [PRIO_W-1:0] lvl;
    logic [TH_W:0]     last;
    lvl  = prio[t];
    last = tail[lvl];
    if (last < NO_LINK) begin
      link[last[TH_W-1:0]] = {1'b0, t};
    end else begin
      head[lvl] = {1'b0, t};
    end
    tail[lvl] = {1'b0, t};
    rdy[t]    = 1'b1;
    link[t]   = NO_LINK;
  endfunction

  function automatic sched_result_t schedule_op(input logic [OP_W-1:0]  op,
                                                input logic [TH_W-1:0]  th,
                                                input logic [REQ_W-1:0] rq);
    logic              keep;
    logic [PRIO_W-1:0] newp;
    logic [PRIO_W-1:0] lvl;
    logic [PRIO_W-1:0] oldp;
    logic              have_old;
    status_e           st;
    sched_result_t     r;
    keep     = rq[REQ_W-1];
    newp     = rq[PRIO_W-1:0];
    st       = ST_IGNORED;
    oldp     = '0;
    have_old = 1'b0;
    case (op)
      OP_TAKE: begin
        if (!cur_held) begin
          st = ST_NO_CUR;
        end else if (rdy[cur]) begin
          lvl = prio[cur];
          if (head[lvl] == {1'b0, cur}) begin
            head[lvl] = link[cur];
            if (head[lvl] >= NO_LINK) begin
              head[lvl] = NO_LINK;
              tail[lvl] = NO_LINK;
            end
            rdy[cur]  = 1'b0;
            link[cur] = NO_LINK;
            st        = ST_DONE;
          end
        end
      end
      OP_APPEND: begin
        if (!cur_held) begin
          st = ST_NO_CUR;
        end else if (!rdy[cur]) begin
          enqueue(cur);
          st = ST_DONE;
        end
      end
      OP_SELECT: begin
        if (!(cur_held && cur == th)) begin
          cur      = th;
          cur_held = 1'b1;
          st       = ST_DONE;
        end
      end
      OP_CHPRIO: begin
        if (!cur_held) begin
          st = ST_NO_CUR;
        end else begin
          oldp     = prio[cur];
          have_old = 1'b1;
          if (!rdy[cur]) begin
            if (!keep) prio[cur] = newp;
            enqueue(cur);
            st = ST_DONE;
          end
        end
      end
      OP_SCHED: begin
        st = ST_NONE_READY;
        for (int i = 0; i < NLVL; i++) begin
          if (st == ST_NONE_READY && head[i] < NO_LINK) begin
            cur      = head[i][TH_W-1:0];
            cur_held = 1'b1;
            st       = ST_DONE;
          end
        end
      end
      OP_INSTALL: begin
        if (!rdy[th]) begin
          // an idle current thread goes back on its queue first
          if (cur_held && !rdy[cur]) enqueue(cur);
          if (!keep) prio[th] = newp;
          link[th] = NO_LINK;
          cur      = th;
          cur_held = 1'b1;
          enqueue(th);
          st = ST_DONE;
        end
      end
      OP_CLEAR: begin
        if (cur_held) begin
          cur_held = 1'b0;
          st       = ST_DONE;
        end
      end
      default: st = ST_IGNORED;
    endcase
    if (!have_old) oldp = cur_held ? prio[cur] : '0;
    r.status = st;
    r.thread = cur_held ? cur : '0;
    r.valid  = cur_held;
    r.prio   = oldp;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      clear_queues();
      expected_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d thread %0d", $time,
                   res_i.status, res_i.current_thread);
          fails++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (res_i.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, res_i.status);
            fails++;
          end
          if (res_i.current_thread !== want.thread) begin
            $display("%0t: current_thread mismatch, expected %0d, actual %0d", $time,
                     want.thread, res_i.current_thread);
            fails++;
          end
          if (res_i.current_valid !== want.valid) begin
            $display("%0t: current_valid mismatch, expected %0d, actual %0d", $time,
                     want.valid, res_i.current_valid);
            fails++;
          end
          if (res_i.old_priority !== want.prio) begin
            $display("%0t: old_priority mismatch, expected %0d, actual %0d", $time,
                     want.prio, res_i.old_priority);
            fails++;
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        expected_q.push_back(schedule_op(cmd_i.op, cmd_i.thread, cmd_i.priority_req));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
  end

endmodule

### tb/sv/tb_priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps

module tb_priority_ready_queue_scheduler;
  import prqs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED    = 3'd7;
  localparam int              RANDOM_ITEMS = 1400;
  localparam int              PHASE_ITEMS  = 150;
  localparam int              HOLD_CYCLES  = 300;
  localparam int              TAIL_CYCLES  = 12;
  localparam int              CYCLE_LIMIT  = 500000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  prqs_in_if  cmd_if ();
  prqs_out_if res_if ();

  int fail_count;
  int pending;
  int checked;
  int cycles     = 0;
  int sent       = 0;
  int directed   = 0;
  int drains     = 0;
  int hold_total = 0;
  bit tx_idle    = 1'b1;
  bit rx_idle    = 1'b1;
  bit hold_req   = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  priority_ready_queue_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  prqs_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    res_if.ready = 1'b0;
    forever begin
      if (hold_req) begin
        stall      = HOLD_CYCLES;
        hold_total = hold_total + HOLD_CYCLES;
        hold_req   = 1'b0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 17) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [TH_W-1:0] th,
                           input logic [REQ_W-1:0] rq);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.op           <= op;
    cmd_if.thread       <= th;
    cmd_if.priority_req <= rq;
    do @(posedge clk_i); while (!cmd_if.ready);
    sent++;
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    drains++;
  endtask

  // mostly low levels so queues share levels; sign bit set means keep
  function automatic logic [REQ_W-1:0] pick_prio();
    return ($urandom_range(0, 3) == 0) ? REQ_W'($urandom_range(0, 31))
                                       : REQ_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [TH_W-1:0] pick_thread();
    return TH_W'($urandom_range(0, 7));
  endfunction

  task automatic run_sequence();
    logic [OP_W-1:0] no_cur_ops [4];
    no_cur_ops = '{OP_TAKE, OP_APPEND, OP_CHPRIO, OP_CLEAR};
    case ($urandom_range(0, 9))
      0, 1, 2: send_item(OP_INSTALL, pick_thread(), pick_prio());
      3, 4: begin
        send_item(OP_SCHED, pick_thread(), pick_prio());
        send_item(OP_TAKE, pick_thread(), pick_prio());
        send_item(OP_CHPRIO, pick_thread(), pick_prio());
      end
      5: begin
        send_item(OP_SCHED, pick_thread(), pick_prio());
        send_item(OP_TAKE, pick_thread(), pick_prio());
        send_item(OP_APPEND, pick_thread(), pick_prio());
      end
      6: begin
        send_item(OP_SELECT, pick_thread(), pick_prio());
        send_item(OP_TAKE, pick_thread(), pick_prio());
      end
      7: begin
        send_item(OP_SELECT, pick_thread(), pick_prio());
        send_item(OP_CHPRIO, pick_thread(), pick_prio());
      end
      8: begin
        send_item(OP_CLEAR, pick_thread(), pick_prio());
        send_item(no_cur_ops[$urandom_range(0, 3)], pick_thread(), pick_prio());
      end
      default: send_item(OP_W'($urandom_range(0, 7)), pick_thread(), pick_prio());
    endcase
  endtask

  initial begin
    int  phase_start;
    bit  hold_done;
    cmd_if.valid        = 1'b0;
    cmd_if.op           = OP_TAKE;
    cmd_if.thread       = '0;
    cmd_if.priority_req = '0;
    hold_done           = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_UNUSED, 3'd7, 5'h1F);
    send_item(OP_TAKE, 3'd0, 5'd0);      // nothing current
    send_item(OP_APPEND, 3'd7, 5'd15);
    send_item(OP_CHPRIO, 3'd0, 5'd3);
    send_item(OP_CLEAR, 3'd0, 5'd0);
    send_item(OP_SCHED, 3'd0, 5'd0);     // all levels empty
    send_item(OP_SELECT, 3'd2, 5'd0);
    send_item(OP_SELECT, 3'd2, 5'd0);    // already current
    send_item(OP_INSTALL, 3'd7, 5'd15);  // idle current queued first
    send_item(OP_INSTALL, 3'd0, 5'd0);
    send_item(OP_INSTALL, 3'd0, 5'd9);   // already ready
    send_item(OP_INSTALL, 3'd3, 5'h1F);  // keeps old priority
    send_item(OP_INSTALL, 3'd5, 5'h10);
    send_item(OP_SCHED, 3'd0, 5'd0);
    send_item(OP_TAKE, 3'd0, 5'd0);
    send_item(OP_TAKE, 3'd0, 5'd0);      // not ready
    send_item(OP_APPEND, 3'd0, 5'd0);
    send_item(OP_APPEND, 3'd0, 5'd0);    // already ready
    send_item(OP_SELECT, 3'd5, 5'd0);
    send_item(OP_TAKE, 3'd0, 5'd0);      // not at head of its level
    send_item(OP_CHPRIO, 3'd0, 5'd6);    // still queued
    send_item(OP_SELECT, 3'd7, 5'd0);
    send_item(OP_TAKE, 3'd0, 5'd0);
    send_item(OP_CHPRIO, 3'd0, 5'h1F);
    send_item(OP_CLEAR, 3'd0, 5'd0);
    directed = sent;
    wait_drained();

    phase_start = sent;
    while (sent < directed + RANDOM_ITEMS) begin
      if (sent - phase_start >= PHASE_ITEMS) begin
        phase_start = sent;
        tx_idle     = ($urandom_range(0, 2) != 0);
        rx_idle     = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 1) == 1) wait_drained();
      end
      if (!hold_done && sent >= directed + 500) begin
        hold_done = 1'b1;
        tx_idle   = 1'b0;
        hold_req  = 1'b1;
      end
      run_sequence();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run: %0d commands (%0d directed), %0d results checked, all op codes incl. unused",
             sent, directed, checked);
    $display("Output held off %0d cycles with input backed up; block drained %0d times",
             hold_total, drains);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/prqs_pkg.sv
hw/rtl/prqs_if.sv
hw/rtl/prqs_ctrl.sv
hw/rtl/prqs_dp.sv
hw/rtl/priority_ready_queue_scheduler.sv
tb/sv/prqs_checker.sv
tb/sv/tb_priority_ready_queue_scheduler.sv
